### hdl/sbrk_pkg.sv
// Shared types and constants of the saddle block residual kernel.
// No dependencies; sbrk_front, sbrk_back and the top level import this package.
package sbrk_pkg;

  localparam int COL_W       = 12;
  localparam int COL_SPAN    = 1 << COL_W;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = 2 * DATA_W - FRAC_W;
  localparam int LANES       = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef enum logic [1:0] {
    OP_ACCUM,
    OP_ROW_END,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic                         in_range;
    logic                         stride_three;
    logic                         residual_mode;
    logic [COL_W-1:0]             col;
    logic [LANES-1:0][DATA_W-1:0] coef;
    logic [LANES-1:0][DATA_W-1:0] x1;
    logic [DATA_W-1:0]            x2;
    logic [DATA_W-1:0]            rhs;
  } item_t;

endpackage

### hdl/sbrk_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sbrk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sbrk_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on sbrk_pkg.
module sbrk_front #(
  parameter int COLUMN_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          action,
  input  logic [sbrk_pkg::COL_W-1:0]    col_index,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_0,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_1,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_2,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_0,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_1,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_2,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x2_value,
  input  logic signed [sbrk_pkg::DATA_W-1:0] rhs_value,
  input  logic                          row_last,
  input  logic                          stride_three,
  input  logic                          residual_mode,
  input  logic                          busy,
  output logic                          head_valid,
  output sbrk_pkg::item_t               head_item,
  input  logic                          pop
);
  import sbrk_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACTION_NONZERO = 1'b0;
  localparam logic ACTION_DRAIN   = 1'b1;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  item_t           incoming;
  item_t           q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  // Classify: decode the operation, check the column range and drop the
  // coefficients that scalar mode leaves unused.
  always_comb begin
    case (action)
      ACTION_DRAIN:   incoming.op = OP_DRAIN;
      ACTION_NONZERO: incoming.op = row_last ? OP_ROW_END : OP_ACCUM;
      default:        incoming.op = OP_ACCUM;
    endcase
    incoming.in_range      = int'(col_index) < COLUMN_DEPTH;
    incoming.stride_three  = stride_three;
    incoming.residual_mode = residual_mode;
    incoming.col           = col_index;
    incoming.coef[0]       = coef_0;
    incoming.coef[1]       = stride_three ? coef_1 : '0;
    incoming.coef[2]       = stride_three ? coef_2 : '0;
    incoming.x1[0]         = x1_0;
    incoming.x1[1]         = x1_1;
    incoming.x1[2]         = x1_2;
    incoming.x2            = x2_value;
    incoming.rhs           = rhs_value;
  end

  assign item_stall = (count == CntW'(QUEUE_DEPTH)) || busy;
  assign push       = item_valid && !item_stall;
  assign head_valid = count != '0;
  assign head_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> head_valid)
    else $error("queue empty after a push");

  a_empty_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !head_valid)
    else $error("queue holds a request during the clearing pass");

endmodule

### hdl/sbrk_back.sv
// Back end: products, column store read-modify-write, row sum and result register.
// Depends on sbrk_pkg and sbrk_ram.
module sbrk_back #(
  parameter int COLUMN_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  sbrk_pkg::item_t                    head_item,
  output logic                               pop,
  output logic                               busy,
  input  logic                               result_stall,
  output logic                               result_valid,
  output logic                               kind,
  output logic [sbrk_pkg::COL_W-1:0]         index,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_0,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_1,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_2
);
  import sbrk_pkg::*;

  localparam int MemDepth = (COLUMN_DEPTH < COL_SPAN) ? COLUMN_DEPTH : COL_SPAN;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int SpanW    = ACC_W + 2;
  localparam int ExtW     = ACC_W + 3;
  localparam int ProdW    = 2 * DATA_W;

  typedef logic signed [ExtW-1:0] ext_t;
  typedef logic [ACC_W-1:0]       acc_t;

  // Composition of saturating adds: x -> min(max(x + a, lo), hi).
  typedef struct packed {
    logic [SpanW-1:0] a;
    acc_t             lo;
    acc_t             hi;
  } span_t;

  typedef struct packed {
    op_t                          op;
    logic                         residual_mode;
    logic [COL_W-1:0]             index;
    logic [DATA_W-1:0]            rhs;
    logic [LANES-1:0][DATA_W-1:0] vals;
  } carry_t;

  localparam acc_t  AccMax    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t  AccMin    = {1'b1, {(ACC_W-1){1'b0}}};
  localparam span_t SpanIdent = '{a: '0, lo: AccMin, hi: AccMax};

  function automatic ext_t sx(input acc_t v);
    return ext_t'($signed(v));
  endfunction

  function automatic acc_t sat_acc(input ext_t v);
    acc_t r;
    if (v[ExtW-1:ACC_W-1] == '0 || v[ExtW-1:ACC_W-1] == '1) begin
      r = v[ACC_W-1:0];
    end else if (v[ExtW-1]) begin
      r = AccMin;
    end else begin
      r = AccMax;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat_out(input ext_t v);
    logic [DATA_W-1:0] r;
    if (v[ExtW-1:DATA_W-1] == '0 || v[ExtW-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[ExtW-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic span_t add_step(input span_t s, input acc_t p);
    span_t r;
    r.a  = s.a + SpanW'($signed(p));
    r.lo = sat_acc(sx(s.lo) + sx(p));
    r.hi = sat_acc(sx(s.hi) + sx(p));
    return r;
  endfunction

  // Floor of the Q32.32 product back to Q32.16.
  function automatic acc_t qmul(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
    logic signed [ProdW-1:0] p;
    p = $signed(x) * $signed(y);
    return p[FRAC_W +: ACC_W];
  endfunction

  logic                         advance;
  logic [AddrW-1:0]             clr_addr;

  logic                         m_valid;
  op_t                          m_op;
  logic                         m_in_range;
  logic                         m_stride;
  logic                         m_residual;
  logic [COL_W-1:0]             m_col;
  logic [DATA_W-1:0]            m_rhs;
  logic [LANES-1:0][ACC_W-1:0]  m_prow;
  logic [LANES-1:0][ACC_W-1:0]  m_pcol;
  logic [LANES-1:0]             m_fwd_hit;
  logic [LANES-1:0][ACC_W-1:0]  m_fwd_data;
  logic [LANES-1:0][ACC_W-1:0]  m_old;
  logic [LANES-1:0]             m_we;
  logic [LANES-1:0][ACC_W-1:0]  m_wdata;
  logic [LANES-1:0]             fwd_hit_next;
  carry_t                       m_carry;

  logic [LANES-1:0]             ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [LANES-1:0][ACC_W-1:0]  ram_wdata;
  logic [LANES-1:0][ACC_W-1:0]  ram_rdata;

  logic   s2_valid, s3_valid, s4_valid, s5_valid;
  carry_t s2_c, s3_c, s4_c, s4_out, s5_c;
  span_t  s2_span, s3_span, s4_span;
  acc_t   s2_p1, s2_p2, s3_p2;
  acc_t   s5_sum;

  acc_t              rs;
  acc_t              rs_new;
  ext_t              rs_probe;
  logic [COL_W-1:0]  row_num;
  ext_t              row_diff;
  logic [DATA_W-1:0] row_value;

  assign advance = !(result_valid && result_stall);
  assign pop     = advance && head_valid && !busy;

  // Column store stage: merge the write of the request just ahead, add or drain.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      m_old[k] = m_fwd_hit[k] ? m_fwd_data[k] : ram_rdata[k];
      m_carry.vals[k] = m_in_range ? sat_out(sx(m_old[k])) : '0;
      case (m_op)
        OP_DRAIN: begin
          m_we[k]    = 1'b1;
          m_wdata[k] = '0;
        end
        default: begin
          m_we[k]    = (k == 0) || m_stride;
          m_wdata[k] = sat_acc(sx(m_old[k]) + sx(m_pcol[k]));
        end
      endcase
      m_we[k]         = m_we[k] && m_valid && m_in_range && advance;
      fwd_hit_next[k] = m_we[k] && (m_col == head_item.col);
    end
    m_carry.op            = m_op;
    m_carry.residual_mode = m_residual;
    m_carry.index         = m_col;
    m_carry.rhs           = m_rhs;
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ram_we[k]    = busy || m_we[k];
      ram_wdata[k] = busy ? '0 : m_wdata[k];
    end
    ram_waddr = busy ? clr_addr : m_col[AddrW-1:0];
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sbrk_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MemDepth)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata[g]),
      .re    (pop),
      .raddr (head_item.col[AddrW-1:0]),
      .rdata (ram_rdata[g])
    );
  end

  // Row sum recurrence: one add and a clamp between two bounds.
  always_comb begin
    rs_probe = sx(rs) + ext_t'($signed(s4_span.a));
    if (rs_probe < sx(s4_span.lo)) begin
      rs_new = s4_span.lo;
    end else if (rs_probe > sx(s4_span.hi)) begin
      rs_new = s4_span.hi;
    end else begin
      rs_new = rs_probe[ACC_W-1:0];
    end
    s4_out = s4_c;
    if (s4_c.op == OP_ROW_END) begin
      s4_out.index = row_num;
    end
  end

  always_comb begin
    row_diff  = s5_c.residual_mode ? ext_t'($signed(s5_c.rhs)) - sx(s5_sum) : sx(s5_sum);
    row_value = sat_out(row_diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      clr_addr     <= '0;
      m_valid      <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
      rs           <= '0;
      row_num      <= '0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AddrW'(MemDepth - 1)) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        m_valid      <= pop;
        s2_valid     <= m_valid;
        s3_valid     <= s2_valid;
        s4_valid     <= s3_valid;
        s5_valid     <= s4_valid;
        result_valid <= s5_valid && (s5_c.op != OP_ACCUM);
        if (s4_valid) begin
          case (s4_c.op)
            OP_ACCUM: rs <= rs_new;
            OP_ROW_END: begin
              rs      <= '0;
              row_num <= row_num + 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_op       <= head_item.op;
      m_in_range <= head_item.in_range;
      m_stride   <= head_item.stride_three;
      m_residual <= head_item.residual_mode;
      m_col      <= head_item.col;
      m_rhs      <= head_item.rhs;
      for (int k = 0; k < LANES; k++) begin
        m_prow[k] <= qmul(head_item.coef[k], head_item.x1[k]);
        m_pcol[k] <= qmul(head_item.x2, head_item.coef[k]);
      end
      m_fwd_hit  <= fwd_hit_next;
      m_fwd_data <= m_wdata;
    end
    if (advance) begin
      s2_c    <= m_carry;
      s2_span <= add_step(SpanIdent, m_prow[0]);
      s2_p1   <= m_prow[1];
      s2_p2   <= m_prow[2];
      s3_c    <= s2_c;
      s3_span <= add_step(s2_span, s2_p1);
      s3_p2   <= s2_p2;
      s4_c    <= s3_c;
      s4_span <= add_step(s3_span, s3_p2);
      s5_c    <= s4_out;
      s5_sum  <= rs_new;
      index   <= s5_c.index;
      case (s5_c.op)
        OP_DRAIN: begin
          kind    <= KIND_COLUMN;
          value_0 <= s5_c.vals[0];
          value_1 <= s5_c.vals[1];
          value_2 <= s5_c.vals[2];
        end
        default: begin
          kind    <= KIND_ROW;
          value_0 <= row_value;
          value_1 <= '0;
          value_2 <= '0;
        end
      endcase
    end
  end

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> $signed(s4_span.lo) <= $signed(s4_span.hi))
    else $error("row sum clamp bounds crossed");

  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_valid)
    else $error("popped request missing from column stage");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    advance && s4_valid && s4_c.op == OP_ROW_END |=> rs == '0)
    else $error("row sum not cleared at row end");

endmodule

### hdl/saddle_block_residual_kernel.sv
// Saddle block residual kernel: streams the nonzeros of a row-compressed
// coupling block, forms row products B.x1 (or rhs minus them) and scatter-adds
// x2*B into a per-column store. After reset a clearing pass writes zero to
// all min(COLUMN_DEPTH, 4096) column entries (4096 by default) with item_stall
// held high; configuration writes are taken throughout. Then one request is
// taken every cycle while the output does not stall. A result passes the queue,
// column store stage, s2 to s5 and output register; a four-entry queue lets
// requests keep arriving while the output stalls. The rate is set by the
// column store read-modify-write (one read and one write port per component,
// with the write of the request just ahead forwarded) and by the row sum
// recurrence, which folds up to three saturating adds into one clamp per cycle.
// Depends on sbrk_pkg, sbrk_front, sbrk_back and sbrk_ram.
module saddle_block_residual_kernel #(
  parameter int COLUMN_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               action,
  input  logic [sbrk_pkg::COL_W-1:0]         col_index,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_0,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_1,
  input  logic signed [sbrk_pkg::DATA_W-1:0] coef_2,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_0,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_1,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x1_2,
  input  logic signed [sbrk_pkg::DATA_W-1:0] x2_value,
  input  logic signed [sbrk_pkg::DATA_W-1:0] rhs_value,
  input  logic                               row_last,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               kind,
  output logic [sbrk_pkg::COL_W-1:0]         index,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_0,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_1,
  output logic signed [sbrk_pkg::DATA_W-1:0] value_2,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic                               cfg_data
);
  import sbrk_pkg::*;

  // Register map; other indexes are accepted and dropped.
  localparam logic [1:0] CFG_STRIDE_THREE  = 2'd0;
  localparam logic [1:0] CFG_RESIDUAL_MODE = 2'd1;

  logic            stride_three;
  logic            residual_mode;
  logic            clearing;
  logic            head_valid;
  logic            pop;
  item_t           head_item;

  // Users must change configuration only while idle; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_three  <= 1'b0;
      residual_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIDE_THREE:  stride_three  <= cfg_data;
        CFG_RESIDUAL_MODE: residual_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: take requests, classify them and queue them.
  sbrk_front #(
    .COLUMN_DEPTH (COLUMN_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .col_index     (col_index),
    .coef_0        (coef_0),
    .coef_1        (coef_1),
    .coef_2        (coef_2),
    .x1_0          (x1_0),
    .x1_1          (x1_1),
    .x1_2          (x1_2),
    .x2_value      (x2_value),
    .rhs_value     (rhs_value),
    .row_last      (row_last),
    .stride_three  (stride_three),
    .residual_mode (residual_mode),
    .busy          (clearing),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop)
  );

  // Back end: multiply, update the column store and row sum, drive results.
  sbrk_back #(
    .COLUMN_DEPTH (COLUMN_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .busy         (clearing),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .kind         (kind),
    .index        (index),
    .value_0      (value_0),
    .value_1      (value_1),
    .value_2      (value_2)
  );

endmodule
